FILE: hw/rtl/lts_pkg.sv
// Package for the lottery thread picker: sizes, request codes, the handshake
// structs of the remainder unit and the ticket saturation helper.
// Depends on nothing; lts_if, lts_mod and the top level import it.
`default_nettype none

package lts_pkg;

   // Table geometry.
   localparam int THREADS     = 8;
   localparam int TICKET_BITS = 16;

   // Field widths of the request and response channels.
   localparam int INDEX_BITS  = 3;
   localparam int COUNT_BITS  = 16;
   localparam int RAND_BITS   = 31;
   localparam int CHOSEN_BITS = 3;

   // Derived sizes.
   localparam int IDX_BITS     = $clog2(THREADS);
   localparam int CNT_BITS     = IDX_BITS + 1;
   localparam int SUM_BITS     = TICKET_BITS + IDX_BITS;
   localparam int DIV_CNT_BITS = $clog2(RAND_BITS + 1);
   localparam int TICKET_MAX   = (1 << TICKET_BITS) - 1;

   // Request codes.
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [RAND_BITS-1:0] dividend;
      logic [SUM_BITS-1:0]  divisor;
   } lts_div_req_type;

   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] remainder;
   } lts_div_rsp_type;

   // Clamp a requested ticket count to the width of a table entry.
   function automatic logic [TICKET_BITS-1:0] sat_ticket(input logic [COUNT_BITS-1:0] count);
      logic [TICKET_BITS-1:0] result;
      if (32'(count) > TICKET_MAX) begin
         result = '1;
      end else begin
         result = TICKET_BITS'(count);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lts_if.sv
// Valid/ready channel interfaces of the lottery thread picker.
// Depends on lts_pkg for the field widths.
`default_nettype none

interface lts_req_if
   import lts_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [INDEX_BITS-1:0] thread_index;
   logic [COUNT_BITS-1:0] ticket_count;
   logic [RAND_BITS-1:0]  random_value;

   modport source (output valid, output cmd, output thread_index, output ticket_count,
                   output random_value, input ready);
   modport sink   (input valid, input cmd, input thread_index, input ticket_count,
                   input random_value, output ready);
endinterface

interface lts_rsp_if
   import lts_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CHOSEN_BITS-1:0] chosen_thread;
   logic                   all_done;

   modport source (output valid, output chosen_thread, output all_done, input ready);
   modport sink   (input valid, input chosen_thread, input all_done, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module lts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lts_mod.sv
// Iterative remainder unit: one restoring step per cycle over the random value.
// Depends on lts_pkg for widths and the request/response structs.
`default_nettype none

module lts_mod
   import lts_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lts_div_req_type div_req,
   output lts_div_rsp_type      div_rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic [RAND_BITS-1:0]    shift_ff, shift_in;
   logic [SUM_BITS-1:0]     rem_ff, rem_in;
   logic [SUM_BITS-1:0]     divisor_ff, divisor_in;
   logic [SUM_BITS:0]       trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[RAND_BITS-1]};

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_BITS'(RAND_BITS);
         shift_in   = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // Bring down the next dividend bit and subtract when it fits.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = SUM_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = SUM_BITS'(trial);
         end
         shift_in = {shift_ff[RAND_BITS-2:0], 1'b0};
         count_in = count_ff - DIV_CNT_BITS'(1);
         if (count_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lottery_thread_picker.sv
// Top level of the lottery thread picker: sequencer, ticket table RAM,
// per-entry valid bits, remainder unit and the response register.
// Depends on lts_pkg, lts_if (channel interfaces), lts_ram and lts_mod.
//
//   Channel    Direction  Carries
//   --------   ---------  ----------------------------------------------------
//   req_chan   in         cmd, thread_index, ticket_count, random_value
//   rsp_chan   out        chosen_thread, all_done (one response per draw)
//
// A set sends no response. A draw runs a RAM pass to total the tickets, one
// divider step per random bit, then a second pass that stops at the winner.
// A draw over an empty table skips the divide and the scan.
// Synchronous reset clears the per-entry valid bits, so no clearing pass runs.
// A stalled response holds in its register while new requests are taken; a
// finished draw waits in ST_OUT until that register frees up.
`default_nettype none

module lottery_thread_picker
   import lts_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   lts_req_if.sink  req_chan,
   lts_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_BITS-1:0]    pend_idx_ff, pend_idx_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [RAND_BITS-1:0]   rnd_ff, rnd_in;
   logic [SUM_BITS-1:0]    rem_ff, rem_in;
   logic [IDX_BITS-1:0]    pick_ff, pick_in;
   logic                   none_ff, none_in;
   logic [THREADS-1:0]     tvalid_ff, tvalid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHOSEN_BITS-1:0] rsp_thread_ff, rsp_thread_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                   req_accept;
   logic                   idx_ok;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_idx;
   logic                   rd_en;
   logic [TICKET_BITS-1:0] rd_data;
   logic [TICKET_BITS-1:0] entry;
   logic [SUM_BITS-1:0]    acc;
   logic                   walk_last;
   logic                   rsp_load;
   lts_div_req_type        div_req;
   lts_div_rsp_type        div_rsp;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign idx_ok     = 32'(req_chan.thread_index) < THREADS;
   assign wr_idx     = IDX_BITS'(req_chan.thread_index);
   assign wr_en      = req_accept && (req_chan.cmd == CMD_SET) && idx_ok;

   // Reads are issued one entry per cycle during both passes; the data comes
   // back in the following cycle, tagged by pend_ff and pend_idx_ff.
   assign rd_en = ((state_ff == ST_SUM) || (state_ff == ST_SCAN))
                  && (issue_cnt_ff < CNT_BITS'(THREADS));

   // An entry never written since reset counts as zero tickets.
   assign entry     = (pend_ff && tvalid_ff[pend_idx_ff]) ? rd_data : '0;
   assign acc       = sum_ff + SUM_BITS'(entry);
   assign walk_last = pend_ff && (issue_cnt_ff == CNT_BITS'(THREADS));

   lts_ram #(
      .WIDTH (TICKET_BITS),
      .DEPTH (THREADS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (sat_ticket(req_chan.ticket_count)),
      .rd_en   (rd_en),
      .rd_addr (issue_cnt_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign div_req.start    = (state_ff == ST_SUM) && walk_last && (acc != '0);
   assign div_req.dividend = rnd_ff;
   assign div_req.divisor  = acc;

   lts_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = rd_en;
      pend_idx_in   = issue_cnt_ff[IDX_BITS-1:0];
      sum_in        = sum_ff;
      rnd_in        = rnd_ff;
      rem_in        = rem_ff;
      pick_in       = pick_ff;
      none_in       = none_ff;
      tvalid_in     = tvalid_ff;
      rsp_thread_in = rsp_thread_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (wr_en) begin
         tvalid_in[wr_idx] = 1'b1;
      end
      if (rd_en) begin
         issue_cnt_in = issue_cnt_ff + CNT_BITS'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_chan.cmd == CMD_DRAW)) begin
               rnd_in       = req_chan.random_value;
               issue_cnt_in = '0;
               sum_in       = '0;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               sum_in = acc;
            end
            if (walk_last) begin
               if (acc == '0) begin
                  pick_in  = '0;
                  none_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // sum_ff holds the total here; it becomes the running sum next.
            if (div_rsp.done) begin
               rem_in       = div_rsp.remainder;
               sum_in       = '0;
               issue_cnt_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               sum_in = acc;
               if (acc > rem_ff) begin
                  pick_in  = pend_idx_ff;
                  none_in  = 1'b0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_thread_in = CHOSEN_BITS'(pick_ff);
               rsp_done_in   = none_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         tvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         tvalid_ff    <= tvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_cnt_ff  <= issue_cnt_in;
      pend_idx_ff   <= pend_idx_in;
      sum_ff        <= sum_in;
      rnd_ff        <= rnd_in;
      rem_ff        <= rem_in;
      pick_ff       <= pick_in;
      none_ff       <= none_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.chosen_thread = rsp_thread_ff;
   assign rsp_chan.all_done      = rsp_done_ff;

`ifndef ASSERT_OFF
   // The remainder unit only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("remainder unit finished outside the divide state");

   // The remainder is always below the ticket total held during the divide.
   a_rem_below_total: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (div_rsp.remainder < sum_ff))
      else $error("remainder not below the ticket total");

   // The second pass must find a winner no later than the last entry.
   a_scan_finds_pick: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && walk_last) |-> (acc > rem_ff))
      else $error("scan reached the last entry without a winner");

   // A new response is only loaded into a free or draining response register.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff && $stable(rsp_thread_ff))
      else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire
